/* rtl/core/plist_pkg.sv */
package plist_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int ENTRY_WIDTH_DEF = 32;

    // Fixed widths of the channel fields.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REPLACE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY_TRAV = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REPLACE,
        CELL_SHIFT_DOWN,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_TRAV
    } state_t;

endpackage

/* rtl/core/plist_if.sv */
interface plist_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [plist_pkg::CMD_W-1:0]    command;
    logic [plist_pkg::POS_W-1:0]    position;
    logic [plist_pkg::VALUE_W-1:0]  item_value;

    modport source (output valid, output command, output position, output item_value,
                    input ready);
    modport sink   (input valid, input command, input position, input item_value,
                    output ready);
endinterface

interface plist_res_if;
    logic                            valid;
    logic                            ready;
    logic [plist_pkg::VALUE_W-1:0]   result_value;
    logic [plist_pkg::STATUS_W-1:0]  status;
    logic [plist_pkg::COUNT_W-1:0]   entry_count;
    logic                            is_empty;
    logic                            is_full;
    logic                            last_result;

    modport source (output valid, output result_value, output status, output entry_count,
                    output is_empty, output is_full, output last_result, input ready);
    modport sink   (input valid, input result_value, input status, input entry_count,
                    input is_empty, input is_full, input last_result, output ready);
endinterface

/* rtl/core/plist_cell.sv */
module plist_cell #(
    parameter int INDEX       = 0,
    parameter int ENTRY_WIDTH = plist_pkg::ENTRY_WIDTH_DEF,
    parameter int CNT_W       = 5
) (
    input  logic                    clk,
    input  plist_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]        last_idx,
    input  logic [ENTRY_WIDTH-1:0]  load_value,
    input  logic [ENTRY_WIDTH-1:0]  left_data,
    input  logic [ENTRY_WIDTH-1:0]  right_data,
    input  logic [ENTRY_WIDTH-1:0]  head_data,
    output logic [ENTRY_WIDTH-1:0]  data
);

    localparam int IW = (CNT_W > plist_pkg::POS_W) ? CNT_W : plist_pkg::POS_W;

    logic [ENTRY_WIDTH-1:0] data_reg;
    logic [ENTRY_WIDTH-1:0] data_next;
    logic [IW-1:0]          my_idx;
    logic [IW-1:0]          pos_ext;
    logic [IW-1:0]          last_ext;

    assign my_idx   = IW'(INDEX);
    assign pos_ext  = IW'(ctrl.pos);
    assign last_ext = IW'(last_idx);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            plist_pkg::CELL_INSERT:
            begin
                if (my_idx > pos_ext)
                begin
                    data_next = left_data;
                end
                else if (my_idx == pos_ext)
                begin
                    data_next = load_value;
                end
            end
            plist_pkg::CELL_REPLACE:
            begin
                if (my_idx == pos_ext)
                begin
                    data_next = load_value;
                end
            end
            plist_pkg::CELL_SHIFT_DOWN:
            begin
                if (my_idx >= pos_ext)
                begin
                    data_next = right_data;
                end
            end
            plist_pkg::CELL_ROTATE:
            begin
                // The occupied part turns left by one; the head wraps to the last entry.
                if (my_idx == last_ext)
                begin
                    data_next = head_data;
                end
                else if (my_idx < last_ext)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* rtl/core/positional_list_store_top.sv */
// Ordered list of up to CAPACITY entries held in a row of cells, one entry per cell.
// Commands arrive on the cmd channel and results leave on the res channel; both use
// valid/ready, and a beat moves when both are high.
// Clear, insert, replace, bad-position and full-list commands give one result beat in
// the cycle after the command beat. Insert moves the affected cells at once.
// Retrieve and delete turn the occupied cells once around the row to pick out the
// entry, then load their result from the emit state; delete closes the gap in the
// same cycle the result is loaded.
// Traverse gives count beats, one per cycle while the receiver takes them, loaded
// from the traverse state; the beat that carries the final entry has last_result set.
// An empty list gives a single beat with the empty-traverse status.
// A new command is taken only while no earlier command is at work, and while the
// result register is empty or being drained in the same cycle.
// When the receiver stalls, the result register holds its beat and traversal or the
// final step of delete and retrieve waits with it.
// Reset clears the entry count and the result valid flag; cell contents are undefined
// until written and are never read before that.
module positional_list_store_top #(
    parameter int CAPACITY    = plist_pkg::CAPACITY_DEF,
    parameter int ENTRY_WIDTH = plist_pkg::ENTRY_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    plist_cmd_if.sink          cmd,
    plist_res_if.source        res
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W = $clog2(CAPACITY);
    localparam int IW     = (CNT_W > plist_pkg::POS_W) ? CNT_W : plist_pkg::POS_W;

    plist_pkg::state_t                state_reg;
    plist_pkg::state_t                state_next;
    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic [STEP_W-1:0]                step_reg;
    logic [STEP_W-1:0]                step_next;
    logic [plist_pkg::CMD_W-1:0]      op_reg;
    logic [plist_pkg::CMD_W-1:0]      op_next;
    logic [plist_pkg::POS_W-1:0]      pos_reg;
    logic [plist_pkg::POS_W-1:0]      pos_next;
    logic [ENTRY_WIDTH-1:0]           cap_reg;
    logic [ENTRY_WIDTH-1:0]           cap_next;

    logic                             res_valid_reg;
    logic [plist_pkg::VALUE_W-1:0]    res_value_reg;
    logic [plist_pkg::VALUE_W-1:0]    res_value_next;
    logic [plist_pkg::STATUS_W-1:0]   res_status_reg;
    logic [plist_pkg::STATUS_W-1:0]   res_status_next;
    logic [CNT_W-1:0]                 res_cnt_reg;
    logic                             res_last_reg;
    logic                             res_last_next;
    logic                             res_load;

    plist_pkg::cell_ctrl_t            cell_ctrl;
    logic [CNT_W-1:0]                 last_idx;
    logic [ENTRY_WIDTH-1:0]           load_value;
    logic [ENTRY_WIDTH-1:0]           cell_data [CAPACITY];

    logic                             out_free;
    logic                             cmd_ready;
    logic                             accept;
    logic [IW-1:0]                    pos_ext;
    logic [IW-1:0]                    cnt_ext;
    logic                             step_at_last;
    logic                             step_at_pos;

    assign out_free     = !res_valid_reg || res.ready;
    assign cmd_ready    = (state_reg == plist_pkg::S_IDLE) && out_free;
    assign accept       = cmd.valid && cmd_ready;
    assign cmd.ready    = cmd_ready;

    assign last_idx     = count_reg - 1'b1;
    assign pos_ext      = IW'(cmd.position);
    assign cnt_ext      = IW'(count_reg);
    assign step_at_last = (CNT_W'(step_reg) == last_idx);
    assign step_at_pos  = (IW'(step_reg) == IW'(pos_reg));
    assign load_value   = ENTRY_WIDTH'(cmd.item_value);

    // Row of cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ENTRY_WIDTH-1:0] left_in;
        logic [ENTRY_WIDTH-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = cell_data[0];
        end
        else
        begin : g_inner_left
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_in = cell_data[i+1];
        end

        plist_cell #(
            .INDEX       (i),
            .ENTRY_WIDTH (ENTRY_WIDTH),
            .CNT_W       (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .last_idx   (last_idx),
            .load_value (load_value),
            .left_data  (left_in),
            .right_data (right_in),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        cap_next        = cap_reg;
        res_load        = 1'b0;
        res_value_next  = '0;
        res_status_next = plist_pkg::ST_OK;
        res_last_next   = 1'b1;
        cell_ctrl.op    = plist_pkg::CELL_HOLD;
        cell_ctrl.pos   = (state_reg == plist_pkg::S_IDLE) ? cmd.position : pos_reg;

        unique case (state_reg)
            plist_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = cmd.command;
                    pos_next = cmd.position;
                    step_next = '0;
                    unique case (cmd.command) inside
                        plist_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            res_load   = 1'b1;
                        end
                        plist_pkg::CMD_INSERT:
                        begin
                            res_load = 1'b1;
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = plist_pkg::ST_FULL;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                res_status_next = plist_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                cell_ctrl.op = plist_pkg::CELL_INSERT;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        plist_pkg::CMD_DELETE, plist_pkg::CMD_RETRIEVE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                res_load        = 1'b1;
                                res_status_next = plist_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                state_next = plist_pkg::S_SCAN;
                            end
                        end
                        plist_pkg::CMD_REPLACE:
                        begin
                            res_load = 1'b1;
                            if (pos_ext >= cnt_ext)
                            begin
                                res_status_next = plist_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                cell_ctrl.op = plist_pkg::CELL_REPLACE;
                            end
                        end
                        plist_pkg::CMD_TRAVERSE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load        = 1'b1;
                                res_status_next = plist_pkg::ST_EMPTY_TRAV;
                            end
                            else
                            begin
                                state_next = plist_pkg::S_TRAV;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            plist_pkg::S_SCAN:
            begin
                // The head cell holds entry step_reg before this turn.
                cell_ctrl.op = plist_pkg::CELL_ROTATE;
                if (step_at_pos)
                begin
                    cap_next = cell_data[0];
                end
                step_next = step_reg + 1'b1;
                if (step_at_last)
                begin
                    state_next = plist_pkg::S_EMIT;
                end
            end
            plist_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    res_load       = 1'b1;
                    res_value_next = plist_pkg::VALUE_W'(cap_reg);
                    if (op_reg == plist_pkg::CMD_DELETE)
                    begin
                        cell_ctrl.op = plist_pkg::CELL_SHIFT_DOWN;
                        count_next   = count_reg - 1'b1;
                    end
                    state_next = plist_pkg::S_IDLE;
                end
            end
            plist_pkg::S_TRAV:
            begin
                if (out_free)
                begin
                    res_load       = 1'b1;
                    res_value_next = plist_pkg::VALUE_W'(cell_data[0]);
                    res_last_next  = step_at_last;
                    cell_ctrl.op   = plist_pkg::CELL_ROTATE;
                    step_next      = step_reg + 1'b1;
                    if (step_at_last)
                    begin
                        state_next = plist_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = plist_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plist_pkg::S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        pos_reg <= pos_next;
        cap_reg <= cap_next;
        if (res_load)
        begin
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            res_cnt_reg    <= count_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.result_value = res_value_reg;
    assign res.status       = res_status_reg;
    assign res.entry_count  = plist_pkg::COUNT_W'(res_cnt_reg);
    assign res.is_empty     = (res_cnt_reg == '0);
    assign res.is_full      = (res_cnt_reg == CNT_W'(CAPACITY));
    assign res.last_result  = res_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plist_pkg::S_SCAN || state_reg == plist_pkg::S_TRAV)
        |-> count_reg != '0)
        else $error("cell scan started on an empty list");

    a_trav_enter: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == plist_pkg::CMD_TRAVERSE && count_reg != '0
        |=> state_reg == plist_pkg::S_TRAV)
        else $error("traverse of a filled list did not start");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(accept) || $past(state_reg == plist_pkg::S_EMIT))
        else $error("entry count changed outside a command");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == plist_pkg::CMD_RETRIEVE && pos_ext < cnt_ext
        |=> !cmd.ready && !res_load)
        else $error("retrieve did not hold off the command channel while scanning");

endmodule
